// ----- src/fl4_pkg.sv -----
// Shared types and constants for the two-lane fourth-order Fletcher checksum.
// No dependencies; imported by every module of the block.
package fl4_pkg;

  localparam int unsigned SUM_W  = 64;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned LANES  = 2;
  localparam int unsigned ORDERS = 4;

  typedef logic [SUM_W-1:0] sum_t;

  // Control that travels down the chain beside each item.
  typedef struct packed {
    logic valid;
    logic last;
  } fl4_stage_t;

endpackage

// ----- src/fletcher4_two_lane_checksum_top.sv -----
// Two-lane fourth-order Fletcher checksum, one 64-bit item per cycle.
// A last item's checksum moves down the chain stages and is then loaded into
// the output register, from which it can be taken.
// Throughput: one item per cycle; the chain halts only while a finished checksum
// waits in the output register and the next one has reached the chain's end.
// Reset clears byte_order, all valid flags and marks every cell as cleared.
// Depends on fl4_pkg, fl4_lane and fl4_merge.
module fletcher4_two_lane_checksum_top
  import fl4_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_word_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] sum_a_o,
  output logic [63:0] sum_b_o,
  output logic [63:0] sum_c_o,
  output logic [63:0] sum_d_o
);

  // The byte_order register: when set, each 32-bit word is byte-reversed.
  logic byte_order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_order_q <= 1'b0;
    end else if (cfg_we_i) begin
      byte_order_q <= cfg_data_i;
    end
  end

  // Split the item into its two words and apply the byte order.
  logic [LANES-1:0][WORD_W-1:0] word_raw, word_sel;

  assign word_raw = data_word_i;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      word_sel[l] = byte_order_q
        ? {word_raw[l][7:0], word_raw[l][15:8], word_raw[l][23:16], word_raw[l][31:24]}
        : word_raw[l];
    end
  end

  // Stage k carries the control of the item whose order-(k+1) sums sit in
  // the cells of that column. The whole chain moves together on adv.
  fl4_stage_t [ORDERS-1:0] st_q;
  fl4_stage_t [ORDERS-1:0] cell_ctrl;
  fl4_stage_t              in_ctrl;
  logic                    adv;
  logic                    out_valid_q;
  logic                    fin_last;

  assign in_ctrl  = '{valid: in_valid_i, last: last_word_i};
  assign fin_last = st_q[ORDERS-1].valid && st_q[ORDERS-1].last;

  // Hold the chain only when a new checksum would overwrite one still waiting.
  assign adv        = !(fin_last && out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  always_comb begin
    cell_ctrl[0] = in_ctrl;
    for (int k = 1; k < ORDERS; k++) begin
      cell_ctrl[k] = st_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (adv) begin
      st_q <= {st_q[ORDERS-2:0], in_ctrl};
    end
  end

  // Two rows of cells, one per lane.
  sum_t [LANES-1:0][ORDERS-1:0] lane_sums;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    fl4_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .ctrl_i (cell_ctrl),
      .word_i (word_sel[l]),
      .sums_o (lane_sums[l])
    );
  end

  // Lane merge, built up while the item walks down the chain.
  sum_t mrg_a, mrg_b, mrg_c, mrg_d;

  fl4_merge u_merge (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .st_i    (st_q),
    .sums_i  (lane_sums),
    .sum_a_o (mrg_a),
    .sum_b_o (mrg_b),
    .sum_c_o (mrg_c),
    .sum_d_o (mrg_d)
  );

  // Output register: loads a finished checksum, keeps it until it is taken.
  sum_t sum_a_q, sum_b_q, sum_c_q, sum_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && fin_last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && fin_last) begin
      sum_a_q <= mrg_a;
      sum_b_q <= mrg_b;
      sum_c_q <= mrg_c;
      sum_d_q <= mrg_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sum_a_o     = sum_a_q;
  assign sum_b_o     = sum_b_q;
  assign sum_c_o     = sum_c_q;
  assign sum_d_o     = sum_d_q;

  // The input is held off only when the chain end has a checksum blocked.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && fin_last))
    else $error("input stalled without a blocked checksum");

  // An accepted last item enters the first stage as a last item.
  a_last_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_word_i) |=> (st_q[0].valid && st_q[0].last))
    else $error("accepted last item lost at chain entry");

  // A last item leaving the chain always produces a valid checksum.
  a_last_leaves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && fin_last) |=> out_valid_o)
    else $error("checksum not presented after chain end");

  // A waiting checksum is never dropped by the chain moving.
  a_no_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && !fin_last) |=> out_valid_o)
    else $error("waiting checksum dropped");

endmodule

// ----- src/fl4_cell.sv -----
// One accumulator cell of the chain: adds the value on add_i, from its neighbor or the input word.
// Depends on fl4_pkg.
module fl4_cell
  import fl4_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic clr_i,
  input  sum_t add_i,
  output sum_t sum_o
);

  logic zero_q;
  sum_t acc_q, acc_d;

  // A cleared cell starts from zero; the cleared state is a flag so the sum needs no reset.
  assign acc_d = (zero_q ? '0 : acc_q) + add_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q <= 1'b1;
    end else if (en_i) begin
      zero_q <= clr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign sum_o = acc_q;

endmodule

// ----- src/fl4_lane.sv -----
// One lane: a row of four cells holding the first- to fourth-order sums.
// Depends on fl4_pkg and fl4_cell.
module fl4_lane
  import fl4_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  fl4_stage_t [ORDERS-1:0] ctrl_i,
  input  logic [WORD_W-1:0]       word_i,
  output sum_t [ORDERS-1:0]       sums_o
);

  sum_t [ORDERS-1:0] feed;

  assign feed[0] = {{(SUM_W-WORD_W){1'b0}}, word_i};

  for (genvar k = 0; k < ORDERS; k++) begin : g_cell
    if (k > 0) begin : g_feed
      assign feed[k] = sums_o[k-1];
    end
    fl4_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv_i && ctrl_i[k].valid),
      .clr_i  (ctrl_i[k].last),
      .add_i  (feed[k]),
      .sum_o  (sums_o[k])
    );
  end

endmodule

// ----- src/fl4_merge.sv -----
// Merge of the two lanes into checksum words A to D, built up stage by stage
// alongside the cell chain. Depends on fl4_pkg.
module fl4_merge
  import fl4_pkg::*;
(
  input  logic                               clk_i,
  input  logic                               adv_i,
  input  fl4_stage_t [ORDERS-1:0]            st_i,
  input  sum_t [LANES-1:0][ORDERS-1:0]       sums_i,
  output sum_t                               sum_a_o,
  output sum_t                               sum_b_o,
  output sum_t                               sum_c_o,
  output sum_t                               sum_d_o
);

  sum_t a1_q, nb1_q;
  sum_t a2_q, b2_q, cp2_q, dp2_q;
  sum_t a3_q, b3_q, c3_q, dp3_q;

  // Stage index k holds order k+1 of the item; each merge step takes one order.
  always_ff @(posedge clk_i) begin
    if (adv_i && st_i[0].valid) begin
      a1_q  <= sums_i[0][0] + sums_i[1][0];
      nb1_q <= '0 - sums_i[1][0];
    end
    if (adv_i && st_i[1].valid) begin
      a2_q  <= a1_q;
      b2_q  <= {sums_i[0][1][SUM_W-2:0], 1'b0} + {sums_i[1][1][SUM_W-2:0], 1'b0} + nb1_q;
      cp2_q <= '0 - sums_i[0][1] - sums_i[1][1] - {sums_i[1][1][SUM_W-2:0], 1'b0};
      dp2_q <= sums_i[1][1];
    end
    if (adv_i && st_i[2].valid) begin
      a3_q  <= a2_q;
      b3_q  <= b2_q;
      c3_q  <= {sums_i[0][2][SUM_W-3:0], 2'b0} + {sums_i[1][2][SUM_W-3:0], 2'b0} + cp2_q;
      dp3_q <= dp2_q - {sums_i[0][2][SUM_W-3:0], 2'b0} - {sums_i[1][2][SUM_W-4:0], 3'b0};
    end
  end

  assign sum_a_o = a3_q;
  assign sum_b_o = b3_q;
  assign sum_c_o = c3_q;
  assign sum_d_o = {sums_i[0][3][SUM_W-4:0], 3'b0} + {sums_i[1][3][SUM_W-4:0], 3'b0} + dp3_q;

endmodule
